// ===== rtl/lprd_pkg.sv =====
// Package for the length-prefixed record deframer: field kinds, verdict
// codes, widths and the result record passed from classifier to queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int WORD_W   = 32;
    localparam int VERD_W   = 2;
    localparam int POS_W    = 3;
    localparam int WORD_BYTES = WORD_W / BYTE_W;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field kind doubles as the parser phase.
    typedef enum logic [KIND_W-1:0] {
        PH_VERSION  = 4'd0,
        PH_COUNT    = 4'd1,
        PH_NAME_LEN = 4'd2,
        PH_NAME     = 4'd3,
        PH_TERM     = 4'd4,
        PH_PAY_LEN  = 4'd5,
        PH_PAYLOAD  = 4'd6,
        PH_TRAILER  = 4'd7,
        PH_DONE     = 4'd8
    } phase_t;

    typedef enum logic [VERD_W-1:0] {
        VERD_OK     = 2'd0,
        VERD_TRUNC  = 2'd1,
        VERD_EXCESS = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        phase_t            field_kind;
        logic [WORD_W-1:0] record_number;
        logic              verdict_valid;
        verdict_t          verdict;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/lprd_if.sv =====
// Valid/ready channel interfaces for the deframer input bytes and tagged
// results. Depends on lprd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lprd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lprd_pkg::BYTE_W-1:0] byte_value;
    logic                      is_final;

    modport source (output valid, output byte_value, output is_final, input ready);
    modport sink   (input valid, input byte_value, input is_final, output ready);
endinterface

interface lprd_out_if;
    logic                        valid;
    logic                        ready;
    logic [lprd_pkg::BYTE_W-1:0] byte_out;
    logic [lprd_pkg::KIND_W-1:0] field_kind;
    logic [lprd_pkg::WORD_W-1:0] record_number;
    logic                        verdict_valid;
    logic [lprd_pkg::VERD_W-1:0] verdict;

    modport source (output valid, output byte_out, output field_kind,
                    output record_number, output verdict_valid, output verdict,
                    input ready);
    modport sink   (input valid, input byte_out, input field_kind,
                    input record_number, input verdict_valid, input verdict,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lprd_front.sv =====
// Front part of the deframer: accepts bytes, tracks the parse phase and
// counters, and pushes one tagged result per byte. Depends on lprd_pkg, lprd_if.
`timescale 1ns / 1ps
`default_nettype none

module lprd_front (
    input  wire             clk,
    input  wire             rst_n,
    lprd_in_if.sink         in_ch,
    input  wire             q_ready,
    output logic            push,
    output lprd_pkg::res_t  res
);
    import lprd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] recs_reg, recs_next;
    logic [WORD_W-1:0] index_reg, index_next;

    logic              acc;
    logic [POS_W-1:0]  pos_inc;
    logic [WORD_W-1:0] len_acc;
    logic [WORD_W-1:0] left_dec;
    logic [WORD_W-1:0] recs_dec;

    assign in_ch.ready = q_ready;
    assign acc         = in_ch.valid && q_ready;
    assign push        = acc;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign len_acc  = shift_reg
                    | ({{(WORD_W-BYTE_W){1'b0}}, in_ch.byte_value} << {pos_reg[1:0], 3'b000});
    assign left_dec = left_reg - WORD_W'(1);
    assign recs_dec = recs_reg - WORD_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        recs_next  = recs_reg;
        index_next = index_reg;

        case (phase_reg)
            PH_VERSION:
            begin
                if (pos_inc[2])
                begin
                    pos_next   = '0;
                    phase_next = PH_COUNT;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            PH_COUNT:
            begin
                if (pos_inc[2])
                begin
                    pos_next   = '0;
                    shift_next = '0;
                    recs_next  = len_acc;
                    phase_next = (len_acc != '0) ? PH_NAME_LEN : PH_DONE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    shift_next = len_acc;
                end
            end
            PH_NAME_LEN, PH_PAY_LEN:
            begin
                if (pos_inc[2])
                begin
                    pos_next   = '0;
                    shift_next = '0;
                    left_next  = len_acc;
                    if (phase_reg == PH_NAME_LEN)
                        phase_next = (len_acc != '0) ? PH_NAME : PH_TERM;
                    else
                        phase_next = (len_acc != '0) ? PH_PAYLOAD : PH_TRAILER;
                end
                else
                begin
                    pos_next   = pos_inc;
                    shift_next = len_acc;
                end
            end
            PH_NAME, PH_PAYLOAD:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                    phase_next = (phase_reg == PH_NAME) ? PH_TERM : PH_TRAILER;
            end
            PH_TERM:
            begin
                phase_next = PH_PAY_LEN;
            end
            PH_TRAILER:
            begin
                pos_next = pos_inc;
                if (pos_inc == '0)
                begin
                    recs_next  = recs_dec;
                    index_next = index_reg + WORD_W'(1);
                    phase_next = (recs_dec != '0) ? PH_NAME_LEN : PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        res.byte_out      = in_ch.byte_value;
        res.field_kind    = phase_reg;
        res.record_number = index_reg;
        res.verdict_valid = in_ch.is_final;
        if (!in_ch.is_final)
            res.verdict = VERD_OK;
        else if (phase_reg == PH_DONE)
            res.verdict = VERD_EXCESS;
        else if (phase_next == PH_DONE)
            res.verdict = VERD_OK;
        else
            res.verdict = VERD_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VERSION;
            pos_reg   <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            recs_reg  <= '0;
            index_reg <= '0;
        end
        else if (acc)
        begin
            if (in_ch.is_final)
            begin
                // last byte of a file: back to the header for the next one
                phase_reg <= PH_VERSION;
                pos_reg   <= '0;
                shift_reg <= '0;
                left_reg  <= '0;
                recs_reg  <= '0;
                index_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                recs_reg  <= recs_next;
                index_reg <= index_next;
            end
        end
    end

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_ch.is_final) |=> (phase_reg == PH_VERSION && index_reg == '0))
        else $error("final byte did not restart the parser");

    a_pos_short_outside_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_TRAILER) |-> (pos_reg[2] == 1'b0))
        else $error("byte position out of range for a length field");

    a_hold_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> ($stable(phase_reg) && $stable(index_reg) && $stable(left_reg)))
        else $error("parser state moved without an accepted byte");

endmodule

`default_nettype wire

// ===== rtl/lprd_queue.sv =====
// Back part of the deframer: a short register queue that holds tagged results
// and drives the output channel. Depends on lprd_pkg, lprd_if.
`timescale 1ns / 1ps
`default_nettype none

module lprd_queue #(
    parameter int DEPTH = lprd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  lprd_pkg::res_t  push_data,
    output logic            q_ready,
    lprd_out_if.source      out_ch
);
    import lprd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    res_t             head;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign pop     = out_ch.valid && out_ch.ready;
    assign head    = mem[rd_ptr_reg];

    assign out_ch.valid         = (count_reg != '0);
    assign out_ch.byte_out      = head.byte_out;
    assign out_ch.field_kind    = head.field_kind;
    assign out_ch.record_number = head.record_number;
    assign out_ch.verdict_valid = head.verdict_valid;
    assign out_ch.verdict       = head.verdict;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_ready)
        else $error("push into a full queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_record_deframer.sv =====
// A byte accepted is written into the result queue registers; its tagged
// transaction shows on the output once it reaches the head of the queue.
// Throughput: one byte per cycle while the queue has room; the parse step
// updates only counters; the queue (two entries by default) absorbs stalls.
// Reset (rst_n low, asynchronous): parser returns to the version phase with
// all counters cleared and the queue emptied; queue entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_record_deframer #(
    parameter int QUEUE_DEPTH = lprd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    lprd_in_if.sink    in_ch,
    lprd_out_if.source out_ch
);
    import lprd_pkg::*;

    // Front to back: one tagged result per accepted byte.
    res_t res;
    logic push;
    logic q_ready;

    // Front: classify each byte by the current phase, assemble the
    // little-endian length words, count name/payload/trailer bytes and
    // decide the verdict on the final byte. Stall while the queue is full.
    lprd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_ready (q_ready),
        .push    (push),
        .res     (res)
    );

    // Back: hold finished transactions until the sink takes them, so a
    // stalled output does not stop input while there is room.
    lprd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .q_ready   (q_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
